[hw/rtl/omni3_wfk_pkg.sv]
// Shared widths, angle constants and the quarter-wave sine ROM of the omni kinematics block.
`default_nettype none

package omni3_wfk_pkg;

    localparam int FRACTION_BITS   = 16;
    localparam int SINE_TABLE_BITS = 10;

    localparam int DATA_W    = 32;
    localparam int HEAD_W    = 16;
    localparam int ADDR_W    = 3;
    localparam int PIPE_DEPTH = 7;

    localparam int QUARTER_ENTRIES = (1 << SINE_TABLE_BITS) + 1;
    localparam int SINE_W    = FRACTION_BITS + 1;
    localparam int COEF_W    = FRACTION_BITS + 2;
    localparam int NUM_COEFS = 6;
    localparam int SPIN_W    = 2 * DATA_W;
    localparam int PROD_W    = COEF_W + DATA_W;
    localparam int TSUM_W    = FRACTION_BITS + 35;
    localparam int WIDE_W    = 65 - FRACTION_BITS;
    localparam int RPM_W     = 65;

    localparam logic [HEAD_W-1:0] QUARTER_TURN  = 16'd16384;
    localparam logic [HEAD_W-1:0] OFFSET_30_DEG = 16'd5461;
    localparam logic [HEAD_W-1:0] OFFSET_60_DEG = 16'd10923;

    localparam logic [DATA_W-1:0] UNITY = DATA_W'(64'd1 << FRACTION_BITS);
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [SINE_W-1:0] t_sine_rom [QUARTER_ENTRIES];

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1 << 30;
    localparam logic signed [63:0] ROUND_Q30 = 64'sd1 << (29 - FRACTION_BITS);

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        for (int k = 0; k < QUARTER_ENTRIES; k++) begin
            x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + $signed(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            if (sum > ONE_Q30) begin
                sum = ONE_Q30;
            end
            rom[k] = SINE_W'((sum + ROUND_Q30) >>> (30 - FRACTION_BITS));
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

[hw/rtl/omni3_wfk_cfg.sv]
// APB register block holding the arm length and speed-to-rpm factors.
`default_nettype none

module omni3_wfk_cfg
    import omni3_wfk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [DATA_W-1:0] o_arm_length,
    output logic [DATA_W-1:0] o_speed_to_rpm
);

    localparam logic REG_ARM_LENGTH   = 1'b0;
    localparam logic REG_SPEED_TO_RPM = 1'b1;

    logic [DATA_W-1:0] r_arm_length;
    logic [DATA_W-1:0] r_speed_to_rpm;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_length   <= UNITY;
            r_speed_to_rpm <= UNITY;
        end else if (wr_en) begin
            case (paddr[2])
                REG_ARM_LENGTH:   r_arm_length   <= pwdata;
                REG_SPEED_TO_RPM: r_speed_to_rpm <= pwdata;
                default:          r_arm_length   <= r_arm_length;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ARM_LENGTH:   prdata = r_arm_length;
            REG_SPEED_TO_RPM: prdata = r_speed_to_rpm;
            default:          prdata = '0;
        endcase
    end

    assign o_arm_length   = r_arm_length;
    assign o_speed_to_rpm = r_speed_to_rpm;

endmodule

`default_nettype wire

[hw/rtl/omni3_wfk_trig.sv]
// Two-stage sine and cosine lookup giving the six signed wheel coefficients.
`default_nettype none

module omni3_wfk_trig
    import omni3_wfk_pkg::*;
(
    input  logic              i_clk,
    input  logic [HEAD_W-1:0] i_heading,
    output t_coef             o_coef [NUM_COEFS]
);

    localparam logic [HEAD_W-1:0] ANGLE_OFS [NUM_COEFS] = '{
        QUARTER_TURN,
        16'd0,
        OFFSET_30_DEG,
        OFFSET_30_DEG + QUARTER_TURN,
        OFFSET_60_DEG + QUARTER_TURN,
        OFFSET_60_DEG
    };
    localparam logic OUTER_NEG [NUM_COEFS] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    localparam logic [SINE_TABLE_BITS:0] IDX_TOP = {1'b1, {SINE_TABLE_BITS{1'b0}}};

    logic [SINE_TABLE_BITS:0] n_idx [NUM_COEFS];
    logic                     n_neg [NUM_COEFS];
    logic [SINE_TABLE_BITS:0] r_idx [NUM_COEFS];
    logic                     r_neg [NUM_COEFS];
    t_coef                    r_coef [NUM_COEFS];

    always_comb begin
        logic [HEAD_W-1:0]        angle;
        logic [SINE_TABLE_BITS:0] base;
        for (int j = 0; j < NUM_COEFS; j++) begin
            angle = i_heading + ANGLE_OFS[j];
            base  = {1'b0, angle[13 -: SINE_TABLE_BITS]};
            n_idx[j] = angle[14] ? (IDX_TOP - base) : base;
            n_neg[j] = angle[15] ^ OUTER_NEG[j];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NUM_COEFS; j++) begin
            r_idx[j]  <= n_idx[j];
            r_neg[j]  <= n_neg[j];
            r_coef[j] <= r_neg[j] ? -$signed({1'b0, SINE_ROM[r_idx[j]]})
                                  :  $signed({1'b0, SINE_ROM[r_idx[j]]});
        end
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

[hw/rtl/omni3_wfk_wheel.sv]
// Per-wheel datapath: products, spin add, surface speed saturation and rpm scaling.
`default_nettype none

module omni3_wfk_wheel
    import omni3_wfk_pkg::*;
(
    input  logic                     i_clk,
    input  t_coef                    i_coef_x,
    input  t_coef                    i_coef_y,
    input  logic signed [DATA_W-1:0] i_vx,
    input  logic signed [DATA_W-1:0] i_vy,
    input  logic signed [SPIN_W-1:0] i_spin,
    input  logic [DATA_W-1:0]        i_speed_to_rpm,
    output logic signed [DATA_W-1:0] o_rpm
);

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic [WIDE_W-DATA_W:0] top;
        top = x[WIDE_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
            return x[DATA_W-1:0];
        end else if (x[WIDE_W-1]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

    logic signed [PROD_W-1:0]               r_px;
    logic signed [PROD_W-1:0]               r_py;
    logic signed [TSUM_W-1:0]               r_tsum;
    logic signed [SPIN_W-FRACTION_BITS-1:0] r_hi;
    logic signed [DATA_W-1:0]               r_surface;
    logic signed [RPM_W-1:0]                r_prod;
    logic signed [DATA_W-1:0]               r_rpm;
    logic signed [TSUM_W-1:0]               spin_lo;
    logic signed [WIDE_W-1:0]               surface_sum;

    assign spin_lo = $signed({{(TSUM_W - FRACTION_BITS){1'b0}}, i_spin[FRACTION_BITS-1:0]});
    assign surface_sum = WIDE_W'(r_hi) + WIDE_W'(r_tsum >>> FRACTION_BITS);

    always_ff @(posedge i_clk) begin
        r_px      <= PROD_W'(i_coef_x) * PROD_W'(i_vx);
        r_py      <= PROD_W'(i_coef_y) * PROD_W'(i_vy);
        r_tsum    <= TSUM_W'(r_px) + TSUM_W'(r_py) + spin_lo;
        r_hi      <= $signed(i_spin[SPIN_W-1:FRACTION_BITS]);
        r_surface <= sat32(surface_sum);
        r_prod    <= RPM_W'(r_surface) * RPM_W'($signed({1'b0, i_speed_to_rpm}));
        r_rpm     <= sat32($signed(r_prod[RPM_W-1:FRACTION_BITS]));
    end

    assign o_rpm = r_rpm;

endmodule

`default_nettype wire

[hw/rtl/omni3_world_frame_kinematics.sv]
// Top level of the three-wheel omni inverse kinematics block.
// An item (vx, vy, yaw rate, heading) is taken at every clock edge where start is high and busy
// is low; busy is high only during and right after reset, so one item per cycle is accepted.
// An item's three wheel targets appear for exactly one cycle, marked by o_valid; the receiver
// cannot stall them. The seven stages are the table address, six parallel reads of the constant
// 1025-entry quarter-wave sine ROM together with the arm-length multiply, the velocity
// products, the spin add, surface saturation, the rpm multiply and the final saturation.
// Registers must be written through the APB port while idle; the block does not enforce it.
`default_nettype none

module omni3_world_frame_kinematics
    import omni3_wfk_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_vx,
    input  logic signed [DATA_W-1:0] i_vy,
    input  logic signed [DATA_W-1:0] i_yaw_rate,
    input  logic [HEAD_W-1:0]        i_heading,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_wheel_one_rpm,
    output logic signed [DATA_W-1:0] o_wheel_two_rpm,
    output logic signed [DATA_W-1:0] o_wheel_three_rpm
);

    logic [DATA_W-1:0]        arm_length;
    logic [DATA_W-1:0]        speed_to_rpm;
    t_coef                    coef [NUM_COEFS];

    logic                     r_busy;
    logic [PIPE_DEPTH-1:0]    r_vld;
    logic signed [DATA_W-1:0] r1_vx;
    logic signed [DATA_W-1:0] r1_vy;
    logic signed [DATA_W-1:0] r1_w;
    logic signed [DATA_W-1:0] r2_vx;
    logic signed [DATA_W-1:0] r2_vy;
    logic signed [SPIN_W-1:0] r2_spin;
    logic signed [SPIN_W-1:0] r3_spin;
    logic                     accept;

    assign busy   = r_busy | !i_rst_n;
    assign accept = start & !busy;

    omni3_wfk_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_arm_length   (arm_length),
        .o_speed_to_rpm (speed_to_rpm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[PIPE_DEPTH-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_vx   <= i_vx;
        r1_vy   <= i_vy;
        r1_w    <= i_yaw_rate;
        r2_vx   <= r1_vx;
        r2_vy   <= r1_vy;
        r2_spin <= SPIN_W'($signed({1'b0, arm_length})) * SPIN_W'(r1_w);
        r3_spin <= r2_spin;
    end

    omni3_wfk_trig u_trig (
        .i_clk     (i_clk),
        .i_heading (i_heading),
        .o_coef    (coef)
    );

    omni3_wfk_wheel u_wheel_one (
        .i_clk          (i_clk),
        .i_coef_x       (coef[0]),
        .i_coef_y       (coef[1]),
        .i_vx           (r2_vx),
        .i_vy           (r2_vy),
        .i_spin         (r3_spin),
        .i_speed_to_rpm (speed_to_rpm),
        .o_rpm          (o_wheel_one_rpm)
    );

    omni3_wfk_wheel u_wheel_two (
        .i_clk          (i_clk),
        .i_coef_x       (coef[2]),
        .i_coef_y       (coef[3]),
        .i_vx           (r2_vx),
        .i_vy           (r2_vy),
        .i_spin         (r3_spin),
        .i_speed_to_rpm (speed_to_rpm),
        .o_rpm          (o_wheel_two_rpm)
    );

    omni3_wfk_wheel u_wheel_three (
        .i_clk          (i_clk),
        .i_coef_x       (coef[4]),
        .i_coef_y       (coef[5]),
        .i_vx           (r2_vx),
        .i_vy           (r2_vy),
        .i_spin         (r3_spin),
        .i_speed_to_rpm (speed_to_rpm),
        .o_rpm          (o_wheel_three_rpm)
    );

    assign o_valid = r_vld[PIPE_DEPTH-1];

endmodule

`default_nettype wire

[hw/rtl/omni3_wfk_checker.sv]
// Port-level checks of the omni kinematics block and their binding to the top level.
`default_nettype none

module omni3_wfk_checker
    import omni3_wfk_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic signed [DATA_W-1:0] i_vx,
    input logic signed [DATA_W-1:0] i_vy,
    input logic signed [DATA_W-1:0] i_yaw_rate,
    input logic                     o_valid,
    input logic signed [DATA_W-1:0] o_wheel_one_rpm,
    input logic signed [DATA_W-1:0] o_wheel_two_rpm,
    input logic signed [DATA_W-1:0] o_wheel_three_rpm
);

    a_not_busy_after_reset: assert property (@(posedge i_clk)
        $past(i_rst_n) && i_rst_n |-> !busy)
        else $error("busy is high outside of reset");

    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##7 o_valid)
        else $error("an accepted item gave no result");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 7))
        else $error("a result appeared without an accepted item");

    a_zero_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_vx == 0 && i_vy == 0 && i_yaw_rate == 0 |->
            ##7 (o_wheel_one_rpm == 0 && o_wheel_two_rpm == 0 && o_wheel_three_rpm == 0))
        else $error("a zero command gave nonzero wheel speeds");

endmodule

bind omni3_world_frame_kinematics omni3_wfk_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_vx              (i_vx),
    .i_vy              (i_vy),
    .i_yaw_rate        (i_yaw_rate),
    .o_valid           (o_valid),
    .o_wheel_one_rpm   (o_wheel_one_rpm),
    .o_wheel_two_rpm   (o_wheel_two_rpm),
    .o_wheel_three_rpm (o_wheel_three_rpm)
);

`default_nettype wire
